[rtl/msl_pkg.sv]
// Package: shared types and constants of the servo slew limiter.
`default_nettype none
package msl_pkg;

  localparam int unsigned DUTY_W   = 10;
  localparam int unsigned STEP_W   = 8;
  localparam int unsigned SPAN_W   = 8;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned RAW_W    = 8;
  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [DUTY_W-1:0] DUTY_MAX   = 10'd1023;
  localparam logic [DUTY_W-1:0] DUTY_RESET = 10'd88;

  localparam logic [STEP_W-1:0] SLEW_STEP_RESET    = 8'd3;
  localparam logic [SPAN_W-1:0] SCALE_SPAN_RESET   = 8'd96;
  localparam logic [DUTY_W-1:0] SCALE_OFFSET_RESET = 10'd40;

  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SPAN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_OFFSET = 2'd2;

  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD_MUL,
    ST_CMD_WR,
    ST_TICK
  } msl_state_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic write;
    logic idx_clear;
    logic tick_load;
  } msl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic idx_last;
  } msl_status_t;

endpackage
`default_nettype wire

[rtl/msl_if.sv]
// Interfaces: command/tick input channel and duty report channel.
`default_nettype none
interface msl_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] channel_code;
  logic [7:0] raw_value;

  modport source (output valid, output op, output channel_code, output raw_value, input ready);
  modport sink   (input valid, input op, input channel_code, input raw_value, output ready);
endinterface

interface msl_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] channel;
  logic [9:0] duty;
  logic       last;

  modport source (output valid, output channel, output duty, output last, input ready);
  modport sink   (input valid, input channel, input duty, input last, output ready);
endinterface
`default_nettype wire

[rtl/msl_ctrl.sv]
// Controller: sequences command scaling and the per-channel tick sweep.
`default_nettype none
module msl_ctrl
  import msl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_op,
  output logic             in_ready,
  input  wire msl_status_t status,
  output msl_cmd_t         cmd
);

  msl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_op == OP_TICK) ? ST_TICK : ST_CMD_MUL;
        end
      end
      ST_CMD_MUL: state_nxt = ST_CMD_WR;
      ST_CMD_WR:  state_nxt = ST_IDLE;
      ST_TICK: begin
        if (status.out_free && status.idx_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.idx_clear = 1'b1;
        cmd.capture   = in_valid && (in_op == OP_COMMAND);
      end
      ST_CMD_MUL: cmd.mul   = 1'b1;
      ST_CMD_WR:  cmd.write = 1'b1;
      ST_TICK:    cmd.tick_load = status.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[rtl/msl_datapath.sv]
// Datapath: config registers, duty stores, scaler, slew unit, report register.
`default_nettype none
module msl_datapath
  import msl_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [CODE_W-1:0]     in_channel_code,
  input  wire logic [RAW_W-1:0]      in_raw_value,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [CHAN_W-1:0]          out_channel,
  output logic [DUTY_W-1:0]          out_duty,
  output logic                       out_last,
  input  wire msl_cmd_t              cmd,
  output msl_status_t                status
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CODE_W-1:0]  RAMP_LIMIT = CODE_W'(NUM_CHANNELS);
  localparam logic [CODE_W-1:0]  JUMP_LIMIT = CODE_W'(2 * NUM_CHANNELS);
  localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(NUM_CHANNELS - 1);

  logic [STEP_W-1:0] slew_step_r;
  logic [SPAN_W-1:0] scale_span_r;
  logic [DUTY_W-1:0] scale_offset_r;

  logic [DUTY_W-1:0] target_r  [NUM_CHANNELS];
  logic [DUTY_W-1:0] current_r [NUM_CHANNELS];

  logic [CODE_W-1:0] code_r;
  logic [RAW_W-1:0]  raw_r;
  logic [15:0]       prod_r;
  logic [IDX_W-1:0]  idx_r;

  logic              out_valid_r;
  logic [CHAN_W-1:0] out_channel_r;
  logic [DUTY_W-1:0] out_duty_r;
  logic              out_last_r;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slew_step_r    <= SLEW_STEP_RESET;
      scale_span_r   <= SCALE_SPAN_RESET;
      scale_offset_r <= SCALE_OFFSET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLEW_STEP:    slew_step_r    <= cfg_wdata[STEP_W-1:0];
        CFG_SCALE_SPAN:   scale_span_r   <= cfg_wdata[SPAN_W-1:0];
        CFG_SCALE_OFFSET: scale_offset_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // scaling: x/255 == (x + (x >> 8) + 1) >> 8 for the 16-bit product x = raw * span
  logic [16:0]       div_sum;
  logic [7:0]        quot;
  logic [DUTY_W:0]   scaled_sum;
  logic [DUTY_W-1:0] scaled;
  logic              is_ramp, is_jump;
  logic [CODE_W-1:0] jump_code;
  logic [IDX_W-1:0]  cmd_idx;

  always_comb begin
    div_sum    = {1'b0, prod_r} + 17'({8'd0, prod_r[15:8]}) + 17'd1;
    quot       = div_sum[15:8];
    scaled_sum = {3'd0, quot} + {1'b0, scale_offset_r};
    scaled     = scaled_sum[DUTY_W] ? DUTY_MAX : scaled_sum[DUTY_W-1:0];
    is_ramp    = code_r < RAMP_LIMIT;
    is_jump    = !is_ramp && (code_r < JUMP_LIMIT);
    jump_code  = code_r - RAMP_LIMIT;
    cmd_idx    = is_ramp ? code_r[IDX_W-1:0] : jump_code[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      code_r <= in_channel_code;
      raw_r  <= in_raw_value;
    end
    if (cmd.mul) begin
      prod_r <= raw_r * scale_span_r;
    end
  end

  // slew of the channel under the sweep index
  logic [DUTY_W-1:0] cur, tgt, diff, slewed;
  logic [DUTY_W-1:0] step_ext;

  always_comb begin
    cur      = current_r[idx_r];
    tgt      = target_r[idx_r];
    step_ext = {2'd0, slew_step_r};
    diff     = (cur < tgt) ? (tgt - cur) : (cur - tgt);
    if (diff > step_ext) begin
      slewed = (cur < tgt) ? (cur + step_ext) : (cur - step_ext);
    end else begin
      slewed = tgt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        target_r[i]  <= DUTY_RESET;
        current_r[i] <= DUTY_RESET;
      end
    end else begin
      if (cmd.write && (is_ramp || is_jump)) begin
        target_r[cmd_idx] <= scaled;
        if (is_jump) begin
          current_r[cmd_idx] <= scaled;
        end
      end
      if (cmd.tick_load) begin
        current_r[idx_r] <= slewed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clear) begin
      idx_r <= '0;
    end else if (cmd.tick_load && (idx_r != IDX_LAST)) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  // report register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.tick_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_load) begin
      out_channel_r <= CHAN_W'(idx_r);
      out_duty_r    <= slewed;
      out_last_r    <= (idx_r == IDX_LAST);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel     = out_channel_r;
  assign out_duty        = out_duty_r;
  assign out_last        = out_last_r;
  assign status.out_free = !out_valid_r || out_ready;
  assign status.idx_last = (idx_r == IDX_LAST);

endmodule
`default_nettype wire

[rtl/multichannel_servo_slew_limiter.sv]
// A command beat is captured, multiplied, then scaled and stored, and gives no result.
// A tick beat reports NUM_CHANNELS channels, one beat per cycle while out is ready,
// the first loaded once the controller is in its tick state; set by the single shared slew unit.
// Input is taken again in the idle state, after the command's write state or the sweep's last channel.
// Synchronous active-low reset: all duties to 88, registers to 3 / 96 / 40.
// Top level: multichannel servo slew limiter.
`default_nettype none
module multichannel_servo_slew_limiter
  import msl_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  msl_in_if.sink                     in_stream,
  msl_out_if.source                  out_stream,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  msl_cmd_t    cmd;
  msl_status_t status;

  msl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_stream.valid),
    .in_op    (in_stream.op),
    .in_ready (in_stream.ready),
    .status   (status),
    .cmd      (cmd)
  );

  msl_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_channel_code (in_stream.channel_code),
    .in_raw_value    (in_stream.raw_value),
    .out_ready       (out_stream.ready),
    .out_valid       (out_stream.valid),
    .out_channel     (out_stream.channel),
    .out_duty        (out_stream.duty),
    .out_last        (out_stream.last),
    .cmd             (cmd),
    .status          (status)
  );

endmodule
`default_nettype wire

[rtl/msl_checker.sv]
// Checker: port-level assertions for the slew limiter, bound to the top level.
`default_nettype none
module msl_port_props #(
  parameter int unsigned NUM_CHANNELS = 10
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] out_channel,
  input wire logic [9:0] out_duty,
  input wire logic       out_last
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("report beat valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_channel) && $stable(out_duty)))
    else $error("stalled report beat changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |-> !in_ready)
    else $error("input taken in the middle of a tick sweep");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && (out_channel == $past(out_channel) + 4'd1)))
    else $error("channel reports out of order");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_channel == 4'(NUM_CHANNELS - 1)))
    else $error("last flag on the wrong channel");

endmodule

bind multichannel_servo_slew_limiter msl_port_props #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_msl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_stream.ready),
  .out_valid   (out_stream.valid),
  .out_ready   (out_stream.ready),
  .out_channel (out_stream.channel),
  .out_duty    (out_stream.duty),
  .out_last    (out_stream.last)
);
`default_nettype wire

[sim/msl_checker.sv]
`timescale 1ns / 1ps
// Checker: keeps a duty model of every channel and compares each duty report beat against it.
module msl_checker
  import msl_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  msl_in_if                     in_ch,
  msl_out_if                    out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    ticks_seen,
  output int                    reports_seen
);

  localparam int unsigned SCALE_DIV = 255;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [DUTY_W-1:0] duty;
    logic              last;
  } duty_report_t;

  duty_report_t      report_q[$];
  logic [STEP_W-1:0] slew_step;
  logic [SPAN_W-1:0] scale_span;
  logic [DUTY_W-1:0] scale_offset;
  logic [DUTY_W-1:0] target_duty [NUM_CHANNELS];
  logic [DUTY_W-1:0] current_duty[NUM_CHANNELS];

  function automatic logic [DUTY_W-1:0] scaled_duty(input logic [RAW_W-1:0] raw);
    int unsigned v;
    v = 32'(raw) * 32'(scale_span) / SCALE_DIV + 32'(scale_offset);
    return (v > 32'(DUTY_MAX)) ? DUTY_MAX : DUTY_W'(v);
  endfunction

  function automatic logic [DUTY_W-1:0] slewed(input logic [DUTY_W-1:0] cur,
                                               input logic [DUTY_W-1:0] tgt);
    if (cur < tgt) begin
      return (tgt - cur > DUTY_W'(slew_step)) ? cur + DUTY_W'(slew_step) : tgt;
    end
    if (cur > tgt) begin
      return (cur - tgt > DUTY_W'(slew_step)) ? cur - DUTY_W'(slew_step) : tgt;
    end
    return cur;
  endfunction

  task automatic flag_field(input string field, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch on duty report, expected %0d, got %0d",
               $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    duty_report_t      want;
    logic [DUTY_W-1:0] v;
    int                ch;
    if (!rst_n) begin
      slew_step    = SLEW_STEP_RESET;
      scale_span   = SCALE_SPAN_RESET;
      scale_offset = SCALE_OFFSET_RESET;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        target_duty[i]  = DUTY_RESET;
        current_duty[i] = DUTY_RESET;
      end
      report_q.delete();
      fail_count   = 0;
      ticks_seen   = 0;
      reports_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLEW_STEP:    slew_step    = cfg_wdata[STEP_W-1:0];
          CFG_SCALE_SPAN:   scale_span   = cfg_wdata[SPAN_W-1:0];
          CFG_SCALE_OFFSET: scale_offset = cfg_wdata[DUTY_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        reports_seen++;
        if (report_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected duty report, expected none, got channel %0d duty %0d last %0b",
                   $time, out_ch.channel, out_ch.duty, out_ch.last);
        end else begin
          want = report_q.pop_front();
          flag_field("channel", want.channel, out_ch.channel);
          flag_field("duty", want.duty, out_ch.duty);
          flag_field("last", want.last, out_ch.last);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == OP_TICK) begin
          ticks_seen++;
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            current_duty[i] = slewed(current_duty[i], target_duty[i]);
            report_q.push_back('{channel: CHAN_W'(i), duty: current_duty[i],
                                 last: (i == NUM_CHANNELS - 1)});
          end
        end else begin
          v = scaled_duty(in_ch.raw_value);
          if (in_ch.channel_code < NUM_CHANNELS) begin
            target_duty[in_ch.channel_code] = v;
          end else if (in_ch.channel_code < 2 * NUM_CHANNELS) begin
            ch = int'(in_ch.channel_code) - NUM_CHANNELS;
            target_duty[ch]  = v;
            current_duty[ch] = v;
          end
        end
      end
    end
    pending = report_q.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Testbench top: clock, reset, command and tick stimulus, receiver stalls and verdict.
module testbench;
  import msl_pkg::*;

  localparam int unsigned NUM_CHANNELS = 10;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned SETTLE       = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    ticks_seen;
  int                    reports_seen;
  int unsigned           snd_idle_pct;
  int unsigned           rcv_idle_pct;
  int unsigned           quiet_cycles;

  msl_in_if  in_ch();
  msl_out_if out_ch();

  multichannel_servo_slew_limiter #(.NUM_CHANNELS(NUM_CHANNELS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_ch),
    .out_stream (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  msl_checker #(.NUM_CHANNELS(NUM_CHANNELS)) duty_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .ticks_seen   (ticks_seen),
    .reports_seen (reports_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d reports outstanding",
               $time, quiet_cycles, pending);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input logic op, input logic [CODE_W-1:0] code,
                           input logic [RAW_W-1:0] raw);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.channel_code <= code;
    in_ch.raw_value    <= raw;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
  endtask

  // upper data bits of the 8-bit registers are junk and must be dropped
  task automatic set_config(input logic [STEP_W-1:0] step, input logic [SPAN_W-1:0] span,
                            input logic [DUTY_W-1:0] offset);
    drain();
    repeat (SETTLE) @(negedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLEW_STEP;
    cfg_wdata <= {2'($urandom), step};
    @(negedge clk);
    cfg_index <= CFG_SCALE_SPAN;
    cfg_wdata <= {2'($urandom), span};
    @(negedge clk);
    cfg_index <= CFG_SCALE_OFFSET;
    cfg_wdata <= offset;
    @(negedge clk);
    cfg_index <= CFG_UNMAPPED;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ignored channel codes count as beats like any other
  task automatic random_beats(input int n);
    int done;
    int sel;
    done = 0;
    while (done < n) begin
      sel = $urandom_range(99);
      if (sel < 22) begin
        send_beat(OP_TICK, CODE_W'($urandom), RAW_W'($urandom));
        done++;
      end else if (sel < 86) begin
        send_beat(OP_COMMAND, CODE_W'($urandom_range(2 * NUM_CHANNELS - 1)), RAW_W'($urandom));
        done++;
      end else begin
        send_beat(OP_COMMAND, CODE_W'($urandom_range(255, 2 * NUM_CHANNELS)),
                  RAW_W'($urandom));
        done++;
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_COMMAND;
    in_ch.channel_code = '0;
    in_ch.raw_value    = '0;
    out_ch.ready       = 1'b0;
    snd_idle_pct       = 28;
    rcv_idle_pct       = 61;
    quiet_cycles       = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: tick before any command, ramps, jumps, unknown codes
    send_beat(OP_TICK, 8'h00, 8'h00);
    send_beat(OP_COMMAND, 8'd0, 8'd255);
    send_beat(OP_COMMAND, 8'd9, 8'd0);
    send_beat(OP_COMMAND, 8'd11, 8'd128);
    send_beat(OP_COMMAND, 8'd19, 8'd255);
    send_beat(OP_COMMAND, 8'd20, 8'd77);
    send_beat(OP_COMMAND, 8'd255, 8'd255);
    send_beat(OP_TICK, 8'hff, 8'hff);
    send_beat(OP_TICK, 8'h5a, 8'ha5);

    // zero step, saturating scale
    set_config(8'd0, 8'd255, 10'd1023);
    send_beat(OP_COMMAND, 8'd5, 8'd200);
    send_beat(OP_COMMAND, 8'd16, 8'd1);
    send_beat(OP_TICK, 8'h00, 8'h00);

    // full step, zero span and offset
    set_config(8'd255, 8'd0, 10'd0);
    send_beat(OP_COMMAND, 8'd2, 8'd255);
    send_beat(OP_COMMAND, 8'd13, 8'd0);
    send_beat(OP_TICK, 8'h00, 8'h00);
    send_beat(OP_TICK, 8'h00, 8'h00);

    // scale lands exactly on and just below full scale
    set_config(8'd255, 8'd255, 10'd768);
    send_beat(OP_COMMAND, 8'd4, 8'd255);
    send_beat(OP_COMMAND, 8'd14, 8'd254);
    send_beat(OP_TICK, 8'h00, 8'h00);

    set_config(STEP_W'($urandom_range(1, 12)), SPAN_W'($urandom), DUTY_W'($urandom_range(700)));
    random_beats(40);
    drain();
    random_beats(40);

    snd_idle_pct = 61;
    rcv_idle_pct = 28;
    set_config(8'd1, 8'd255, DUTY_W'($urandom));
    random_beats(75);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_config(STEP_W'($urandom_range(13, 255)), SPAN_W'($urandom), DUTY_W'($urandom_range(300)));
    random_beats(75);

    drain();
    repeat (20) @(negedge clk);
    $display("Checked %0d duty reports from %0d ticks across four directed", reports_seen,
             ticks_seen);
    $display("and three random register settings, with and without stalls on both sides.");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
